// File: src/traffic_burstiness_estimator_defines.svh
// assertion macros for the burstiness estimator
`ifndef TRAFFIC_BURSTINESS_ESTIMATOR_DEFINES_SVH
`define TRAFFIC_BURSTINESS_ESTIMATOR_DEFINES_SVH

// property that must hold at every edge out of reset
`define TBE_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// implication checked in the next cycle
`define TBE_ASSERT_NEXT(label, cond, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error(msg);

`endif

// File: src/tbe_pkg.sv
package tbe_pkg;

    localparam int MAX_STAMPS = 16384;
    localparam int MAX_EPOCHS = 100;
    localparam int ADDR_W     = 14;

    localparam logic [6:0]  EPOCH_RESET = 7'd17;
    localparam logic [14:0] LIMIT_RESET = 15'd10000;

    localparam logic REG_EPOCH_COUNT   = 1'b0;
    localparam logic REG_REQUEST_LIMIT = 1'b1;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_ZERO_SPAN = 2'd1;
    localparam logic [1:0] ST_NO_BURST  = 2'd2;

    typedef struct packed {
        logic [31:0] timestamp;
        logic        is_last;
    } in_item_t;

    typedef struct packed {
        logic [16:0] param_b;
        logic [22:0] param_a;
        logic [6:0]  bursty_epochs;
        logic [14:0] bursty_arrivals;
        logic [14:0] total_arrivals;
        logic [1:0]  status;
    } out_item_t;

    // controller -> datapath
    typedef struct packed {
        logic store_wr;
        logic rd_first;
        logic rd_last;
        logic cap_first;
        logic cap_last;
        logic epoch_init;
        logic bound_start;
        logic walk_start;
        logic walk_step;
        logic epoch_close;
        logic div_start;
        logic div_sel_a;
        logic load_b;
        logic load_a;
        logic clear_count;
        logic out_load;
        logic [1:0] out_status;
    } ctl_t;

    // datapath -> controller
    typedef struct packed {
        logic empty;
        logic zero_span;
        logic walk_take;
        logic last_epoch;
        logic no_burst;
        logic div_done;
    } sts_t;

endpackage

// File: src/traffic_burstiness_estimator.sv
// Burstiness estimator: timestamps are taken one per cycle into a 16384-entry
// memory until an item marked last; then the block stalls its input while it
// reads the first and last stamps, walks the memory once (one stamp a cycle
// within an epoch) against each epoch boundary, and runs a serial divider once
// per epoch for the boundary and, if any epoch is bursty, twice more for b and
// a. An empty or zero-span log answers once the first and last stamps are read,
// and a log with no bursty epoch after the walk, without dividing for b and a.
// The result is held until taken; loading of the next log starts after that.
`include "traffic_burstiness_estimator_defines.svh"

module traffic_burstiness_estimator (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  tbe_pkg::in_item_t     in_data,
    output logic                  out_valid,
    input  logic                  out_stall,
    output tbe_pkg::out_item_t    out_data,
    input  logic                  cfg_we,
    input  logic                  cfg_index,
    input  logic [14:0]           cfg_data
);

    tbe_pkg::ctl_t ctl;
    tbe_pkg::sts_t sts;
    logic [6:0]  epoch_reg;
    logic [14:0] limit_reg;
    logic        in_ready;
    logic        in_fire;
    logic        out_fire;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            epoch_reg <= tbe_pkg::EPOCH_RESET;
            limit_reg <= tbe_pkg::LIMIT_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                tbe_pkg::REG_EPOCH_COUNT:   epoch_reg <= cfg_data[6:0];
                tbe_pkg::REG_REQUEST_LIMIT: limit_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    assign in_stall = !in_ready;
    assign in_fire  = in_valid && in_ready;
    assign out_fire = out_valid && !out_stall;

    tbe_controller u_ctl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_fire   (in_fire),
        .in_last   (in_data.is_last),
        .out_fire  (out_fire),
        .sts       (sts),
        .ctl       (ctl),
        .in_ready  (in_ready),
        .out_valid (out_valid)
    );

    tbe_datapath u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .ctl           (ctl),
        .sts           (sts),
        .in_item       (in_data),
        .epoch_count   (epoch_reg),
        .request_limit (limit_reg),
        .result        (out_data)
    );

    // checks
    `TBE_ASSERT(a_no_overlap, !(out_valid && !in_stall), "input open while result pending")
    `TBE_ASSERT_NEXT(a_last_stalls, in_fire && in_data.is_last, in_stall,
        "input not stalled after last transaction")
    `TBE_ASSERT_NEXT(a_out_clears, out_fire, !out_valid, "result repeated")

endmodule

// File: src/tbe_divider.sv
// restoring divider, one quotient bit a cycle
module tbe_divider (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [63:0] dividend,
    input  logic [31:0] divisor,
    output logic [63:0] quotient,
    output logic        done
);

    logic [63:0] quo_reg, quo_next;
    logic [32:0] rem_reg, rem_next;
    logic [31:0] dsr_reg, dsr_next;
    logic [6:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [32:0] trial;
    logic [33:0] diff;

    // operand load on start, else one shift and subtract step while busy
    always_comb
    begin
        trial     = {rem_reg[31:0], quo_reg[63]};
        diff      = {1'b0, trial} - {2'b00, dsr_reg};
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dsr_next  = dsr_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            quo_next  = dividend;
            rem_next  = '0;
            dsr_next  = divisor;
            cnt_next  = 7'd64;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (!diff[33])
            begin
                rem_next = diff[32:0];
                quo_next = {quo_reg[62:0], 1'b1};
            end
            else
            begin
                rem_next = trial;
                quo_next = {quo_reg[62:0], 1'b0};
            end
            cnt_next = cnt_reg - 7'd1;
            if (cnt_reg == 7'd1)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dsr_reg <= dsr_next;
    end

    assign quotient = quo_reg;
    assign done     = done_reg;

endmodule

// File: src/tbe_datapath.sv
// stamp memory, epoch walk counters and result arithmetic
module tbe_datapath (
    input  logic                 clk,
    input  logic                 rst_n,
    input  tbe_pkg::ctl_t        ctl,
    output tbe_pkg::sts_t        sts,
    input  tbe_pkg::in_item_t    in_item,
    input  logic [6:0]           epoch_count,
    input  logic [14:0]          request_limit,
    output tbe_pkg::out_item_t   result
);

    logic [31:0] mem [tbe_pkg::MAX_STAMPS];
    logic [31:0] rd_data_reg;
    logic [tbe_pkg::ADDR_W-1:0] rd_addr;
    logic [14:0] last_idx;
    logic [14:0] next_idx;

    logic [14:0] count_reg, count_next;
    logic [14:0] cap;
    logic        room;
    logic [31:0] first_reg, last_reg;
    logic [31:0] span;
    logic [6:0]  epochs_reg;
    logic [6:0]  ep_idx_reg;
    logic [14:0] j_reg;
    logic [14:0] cnt_reg;
    logic [6:0]  bursty_reg;
    logic [14:0] barr_reg;
    logic [32:0] bound_reg;
    logic [38:0] acc_reg;
    logic [38:0] acc_sum;
    logic        rd_valid_reg;
    logic [21:0] ecnt;
    logic        is_bursty;

    // divider operands
    logic [63:0] div_dividend;
    logic [31:0] div_divisor;
    logic [63:0] div_q;
    logic        div_done;
    logic [21:0] bn_reg;
    logic [21:0] num_a_reg;

    assign cap  = (request_limit > 15'(tbe_pkg::MAX_STAMPS)) ?
                  15'(tbe_pkg::MAX_STAMPS) : request_limit;
    assign room = count_reg < cap;
    assign span = last_reg - first_reg;
    // span times one plus the index of the epoch being started
    assign acc_sum = acc_reg + {7'd0, span};

    // stamp count register
    always_comb
    begin
        count_next = count_reg;
        if (ctl.clear_count)
            count_next = '0;
        else if (ctl.store_wr && room)
            count_next = count_reg + 15'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            count_reg <= '0;
        else
            count_reg <= count_next;
    end

    // read address selection
    assign last_idx = count_reg - 15'd1;
    assign next_idx = j_reg + 15'd1;

    always_comb
    begin
        rd_addr = j_reg[tbe_pkg::ADDR_W-1:0];
        if (ctl.rd_first)
            rd_addr = '0;
        else if (ctl.rd_last)
            rd_addr = last_idx[tbe_pkg::ADDR_W-1:0];
        else if (ctl.walk_step)
            rd_addr = next_idx[tbe_pkg::ADDR_W-1:0];
    end

    // stamp memory, one write and one registered read port
    always_ff @(posedge clk)
    begin
        if (ctl.store_wr && room)
            mem[count_reg[tbe_pkg::ADDR_W-1:0]] <= in_item.timestamp;
        rd_data_reg <= mem[rd_addr];
    end

    // walk registers
    always_ff @(posedge clk)
    begin
        if (ctl.cap_first)
            first_reg <= rd_data_reg;
        if (ctl.cap_last)
            last_reg <= rd_data_reg;
        if (ctl.epoch_init)
        begin
            epochs_reg <= (epoch_count == 7'd0) ? 7'd1 :
                          (epoch_count > 7'(tbe_pkg::MAX_EPOCHS)) ?
                          7'(tbe_pkg::MAX_EPOCHS) : epoch_count;
            ep_idx_reg <= '0;
            acc_reg    <= '0;
            j_reg      <= '0;
            cnt_reg    <= '0;
            bursty_reg <= '0;
            barr_reg   <= '0;
        end
        if (ctl.bound_start)
            acc_reg <= acc_sum;
        if (ctl.walk_step)
        begin
            j_reg   <= j_reg + 15'd1;
            cnt_reg <= cnt_reg + 15'd1;
        end
        if (ctl.epoch_close)
        begin
            if (is_bursty)
            begin
                bursty_reg <= bursty_reg + 7'd1;
                barr_reg   <= barr_reg + cnt_reg;
            end
            cnt_reg    <= '0;
            ep_idx_reg <= ep_idx_reg + 7'd1;
        end
        if (div_done && !ctl.div_sel_a && ctl.bound_start == 1'b0 && ctl.load_b == 1'b0
            && ctl.load_a == 1'b0)
            bound_reg <= {1'b0, first_reg} + div_q[32:0];
        if (ctl.div_start && !ctl.div_sel_a)
        begin
            bn_reg    <= 22'(bursty_reg) * 22'(count_reg);
            num_a_reg <= 22'(barr_reg) * 22'(epochs_reg);
        end
    end

    assign ecnt      = 22'(epochs_reg) * 22'(cnt_reg);
    assign is_bursty = ecnt > 22'(count_reg);

    // divider serves the boundaries and both results
    always_comb
    begin
        div_dividend = {25'd0, acc_sum};
        div_divisor  = {25'd0, epochs_reg};
        if (ctl.div_sel_a)
        begin
            div_dividend = {26'd0, num_a_reg, 16'd0};
            div_divisor  = {10'd0, bn_reg};
        end
        else if (ctl.div_start)
        begin
            div_dividend = {41'd0, bursty_reg, 16'd0};
            div_divisor  = {25'd0, epochs_reg};
        end
    end

    tbe_divider u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (ctl.div_start || ctl.bound_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .quotient (div_q),
        .done     (div_done)
    );

    // result register
    always_ff @(posedge clk)
    begin
        if (ctl.load_b)
            result.param_b <= div_q[16:0];
        if (ctl.load_a)
            result.param_a <= (div_q > 64'h7FFFFF) ? 23'h7FFFFF : div_q[22:0];
        if (ctl.out_load)
        begin
            result.status          <= ctl.out_status;
            result.total_arrivals  <= count_reg;
            if (ctl.out_status != tbe_pkg::ST_OK)
            begin
                result.param_b <= '0;
                result.param_a <= '0;
            end
            if (ctl.out_status == tbe_pkg::ST_OK)
            begin
                result.bursty_epochs   <= bursty_reg;
                result.bursty_arrivals <= barr_reg;
            end
            else
            begin
                result.bursty_epochs   <= '0;
                result.bursty_arrivals <= '0;
            end
        end
    end

    // status back to the controller
    assign sts.empty      = (count_reg == 15'd0);
    assign sts.zero_span  = (last_reg <= first_reg);
    assign sts.div_done   = div_done;
    assign sts.walk_take  = rd_valid_reg && (j_reg < count_reg) &&
                            ({1'b0, rd_data_reg} <= bound_reg);
    assign sts.last_epoch = (ep_idx_reg == epochs_reg - 7'd1);
    assign sts.no_burst   = (bursty_reg == 7'd0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            rd_valid_reg <= 1'b0;
        else
            rd_valid_reg <= ctl.walk_start || ctl.walk_step;
    end

endmodule

// File: src/tbe_controller.sv
// sequencer: load, read first and last, check, boundary, walk, divide, deliver
module tbe_controller (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_fire,
    input  logic           in_last,
    input  logic           out_fire,
    input  tbe_pkg::sts_t  sts,
    output tbe_pkg::ctl_t  ctl,
    output logic           in_ready,
    output logic           out_valid
);

    localparam logic [3:0] S_LOAD   = 4'd0;
    localparam logic [3:0] S_RDF    = 4'd1;
    localparam logic [3:0] S_RDL    = 4'd2;
    localparam logic [3:0] S_CHECK  = 4'd3;
    localparam logic [3:0] S_BOUND  = 4'd4;
    localparam logic [3:0] S_BWAIT  = 4'd5;
    localparam logic [3:0] S_WRD    = 4'd6;
    localparam logic [3:0] S_WALK   = 4'd7;
    localparam logic [3:0] S_CLOSE  = 4'd8;
    localparam logic [3:0] S_DIVB   = 4'd9;
    localparam logic [3:0] S_WAITB  = 4'd10;
    localparam logic [3:0] S_DIVA   = 4'd11;
    localparam logic [3:0] S_WAITA  = 4'd12;
    localparam logic [3:0] S_OUT    = 4'd13;
    localparam logic [3:0] S_RDL2   = 4'd14;

    logic [3:0] state_reg, state_next;
    logic [1:0] st_reg, st_next;

    always_comb
    begin
        state_next = state_reg;
        st_next    = st_reg;
        ctl        = '0;
        ctl.out_status = st_reg;
        unique case (state_reg)
            S_LOAD:
            begin
                if (in_fire)
                begin
                    ctl.store_wr = 1'b1;
                    if (in_last)
                        state_next = S_RDF;
                end
            end
            S_RDF:
            begin
                ctl.rd_first = 1'b1;
                state_next   = S_RDL;
            end
            S_RDL:
            begin
                ctl.rd_last   = 1'b1;
                ctl.cap_first = 1'b1;
                state_next    = S_RDL2;
            end
            S_RDL2:
            begin
                ctl.cap_last   = 1'b1;
                ctl.epoch_init = 1'b1;
                state_next     = S_CHECK;
            end
            S_CHECK:
            begin
                if (sts.empty || sts.zero_span)
                begin
                    st_next    = tbe_pkg::ST_ZERO_SPAN;
                    state_next = S_OUT;
                    ctl.out_load   = 1'b1;
                    ctl.out_status = tbe_pkg::ST_ZERO_SPAN;
                end
                else
                    state_next = S_BOUND;
            end
            S_BOUND:
            begin
                ctl.bound_start = 1'b1;
                state_next      = S_BWAIT;
            end
            S_BWAIT:
            begin
                if (sts.div_done)
                    state_next = S_WRD;
            end
            S_WRD:
            begin
                ctl.walk_start = 1'b1;
                state_next     = S_WALK;
            end
            S_WALK:
            begin
                if (sts.walk_take)
                    ctl.walk_step = 1'b1;
                else
                    state_next = S_CLOSE;
            end
            S_CLOSE:
            begin
                ctl.epoch_close = 1'b1;
                state_next = sts.last_epoch ? S_DIVB : S_BOUND;
            end
            S_DIVB:
            begin
                if (sts.no_burst)
                begin
                    st_next        = tbe_pkg::ST_NO_BURST;
                    ctl.out_load   = 1'b1;
                    ctl.out_status = tbe_pkg::ST_NO_BURST;
                    state_next     = S_OUT;
                end
                else
                begin
                    ctl.div_start = 1'b1;
                    state_next    = S_WAITB;
                end
            end
            S_WAITB:
            begin
                if (sts.div_done)
                begin
                    ctl.load_b = 1'b1;
                    state_next = S_DIVA;
                end
            end
            S_DIVA:
            begin
                ctl.div_start = 1'b1;
                ctl.div_sel_a = 1'b1;
                state_next    = S_WAITA;
            end
            S_WAITA:
            begin
                ctl.div_sel_a = 1'b1;
                if (sts.div_done)
                begin
                    ctl.load_a     = 1'b1;
                    ctl.out_load   = 1'b1;
                    ctl.out_status = tbe_pkg::ST_OK;
                    st_next        = tbe_pkg::ST_OK;
                    state_next     = S_OUT;
                end
            end
            S_OUT:
            begin
                if (out_fire)
                begin
                    ctl.clear_count = 1'b1;
                    state_next      = S_LOAD;
                end
            end
            default:
                state_next = S_LOAD;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_LOAD;
            st_reg    <= tbe_pkg::ST_OK;
        end
        else
        begin
            state_reg <= state_next;
            st_reg    <= st_next;
        end
    end

    assign in_ready  = (state_reg == S_LOAD);
    assign out_valid = (state_reg == S_OUT);

endmodule
